// ----- hdl/btmx_pkg.sv -----
// Shared constants, command type and helpers for the binary trie min-xor set.
`timescale 1ns / 1ps
`default_nettype none
package btmx_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int KEY_BITS   = 32;
  localparam int FIELD_W    = 32;
  localparam int OP_W       = 2;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int CNT_W      = $clog2(NODE_COUNT + 1);
  localparam int LVL_W      = (KEY_BITS > 2) ? $clog2(KEY_BITS) : 1;
  localparam int NEED_W     = $clog2(KEY_BITS + 1);
  localparam int ENTRY_W    = 2 * IDX_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_XOR    = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_XOR,
    CMD_QUERY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [KEY_BITS-1:0] value;
  } cmd_t;

  // child link of a node entry: hi child in the upper half
  function automatic logic [IDX_W-1:0] link_sel(input logic [ENTRY_W-1:0] entry,
                                                 input logic bit_sel);
    return bit_sel ? entry[ENTRY_W-1:IDX_W] : entry[IDX_W-1:0];
  endfunction

  function automatic logic [ENTRY_W-1:0] link_set(input logic [ENTRY_W-1:0] entry,
                                                   input logic bit_sel,
                                                   input logic [IDX_W-1:0] idx);
    logic [ENTRY_W-1:0] res;
    res = entry;
    if (bit_sel) begin
      res[ENTRY_W-1:IDX_W] = idx;
    end else begin
      res[IDX_W-1:0] = idx;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/btmx_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module btmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hdl/btmx_front.sv -----
// Front end: takes input items, decodes the operation and pushes commands.
`timescale 1ns / 1ps
`default_nettype none
module btmx_front (
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [btmx_pkg::FIELD_W-1:0] s_axis_tdata,  // operand_value
  input  wire logic [btmx_pkg::OP_W-1:0]    s_axis_tuser,  // operation
  input  wire logic                         full_i,
  output logic                              push_o,
  output btmx_pkg::cmd_t                    cmd_o
);
  import btmx_pkg::*;

  logic op_ok;

  always_comb begin
    op_ok       = 1'b1;
    cmd_o.kind  = CMD_INSERT;
    cmd_o.value = s_axis_tdata[KEY_BITS-1:0];
    unique case (s_axis_tuser)
      OP_INSERT: cmd_o.kind = CMD_INSERT;
      OP_XOR:    cmd_o.kind = CMD_XOR;
      OP_QUERY:  cmd_o.kind = CMD_QUERY;
      default:   op_ok      = 1'b0;
    endcase
  end

  assign s_axis_tready = !full_i;
  // unused codes are taken and dropped
  assign push_o        = s_axis_tvalid && !full_i && op_ok;

endmodule
`default_nettype wire

// ----- hdl/btmx_fifo.sv -----
// Short command queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module btmx_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire btmx_pkg::cmd_t cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output btmx_pkg::cmd_t      cmd_o
);
  import btmx_pkg::*;

  cmd_t              slot_q [FIFO_DEPTH];
  logic [FPTR_W-1:0] wptr_q, rptr_q;
  logic [FPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (FPTR_W + 1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/btmx_back.sv -----
// Back end: trie walk, node allocation, xor mask and result register.
`timescale 1ns / 1ps
`default_nettype none
module btmx_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         empty_i,
  input  wire btmx_pkg::cmd_t               cmd_i,
  output logic                              pop_o,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic      [btmx_pkg::FIELD_W-1:0] m_axis_tdata,  // min_xor_value
  output logic                              m_axis_tuser   // overflowed
);
  import btmx_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_ALLOC,
    ST_RESULT
  } state_e;

  state_e              state_q;
  cmd_kind_e           kind_q;
  logic [KEY_BITS-1:0] mask_q, key_q, res_q;
  logic [LVL_W-1:0]    level_q;
  logic [IDX_W-1:0]    node_q, alloc_q, init_q;
  logic [CNT_W-1:0]    used_q;
  logic                ovf_q;

  logic [ENTRY_W-1:0]  rd_data, wr_data;
  logic [IDX_W-1:0]    rd_addr, wr_addr;
  logic                wr_en;

  logic                want, alt_hit, walk_stop, walk_last, ins_miss, fits;
  logic [IDX_W-1:0]    lnk_want, lnk_alt, nx;
  logic [NEED_W-1:0]   need;
  logic [CNT_W-1:0]    free_cnt;
  logic [LVL_W-1:0]    lvl_dn;

  btmx_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_nodes (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  always_comb begin
    want      = (kind_q == CMD_INSERT) ? key_q[level_q] : mask_q[level_q];
    lnk_want  = link_sel(rd_data, want);
    lnk_alt   = link_sel(rd_data, !want);
    alt_hit   = 1'b0;
    walk_stop = 1'b0;
    nx        = lnk_want;
    if (lnk_want == '0) begin
      if (kind_q == CMD_QUERY && lnk_alt != '0) begin
        nx      = lnk_alt;
        alt_hit = 1'b1;
      end else begin
        walk_stop = 1'b1;
      end
    end
    walk_last = (level_q == '0);
    ins_miss  = (kind_q == CMD_INSERT) && walk_stop;
    need      = NEED_W'(level_q) + 1'b1;
    free_cnt  = CNT_W'(NODE_COUNT) - used_q;
    fits      = (CNT_W'(need) <= free_cnt);
    lvl_dn    = level_q - 1'b1;
  end

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state_q)
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = init_q;
        if (init_q < IDX_W'(KEY_BITS)) begin
          wr_data = link_set('0, 1'b0, init_q + 1'b1);
        end
      end
      ST_WALK: begin
        rd_addr = nx;
        if (ins_miss && fits) begin
          wr_en   = 1'b1;
          wr_addr = node_q;
          wr_data = link_set(rd_data, want, used_q[IDX_W-1:0]);
        end
      end
      ST_ALLOC: begin
        wr_en   = 1'b1;
        wr_addr = alloc_q;
        if (level_q != '0) begin
          wr_data = link_set('0, key_q[lvl_dn], alloc_q + 1'b1);
        end
      end
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_INIT;
      kind_q        <= CMD_INSERT;
      mask_q        <= '0;
      key_q         <= '0;
      res_q         <= '0;
      level_q       <= '0;
      node_q        <= '0;
      alloc_q       <= '0;
      init_q        <= '0;
      used_q        <= CNT_W'(KEY_BITS + 1);
      ovf_q         <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tuser  <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state_q != ST_RESULT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state_q)
        ST_INIT: begin
          init_q <= init_q + 1'b1;
          if (init_q == IDX_W'(KEY_BITS)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!empty_i) begin
            kind_q  <= cmd_i.kind;
            key_q   <= cmd_i.value ^ mask_q;
            level_q <= LVL_W'(KEY_BITS - 1);
            node_q  <= '0;
            res_q   <= '0;
            if (cmd_i.kind == CMD_XOR) begin
              mask_q <= mask_q ^ cmd_i.value;
            end else begin
              state_q <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (alt_hit) begin
            res_q[level_q] <= 1'b1;
          end
          if (ins_miss) begin
            if (fits) begin
              used_q  <= used_q + CNT_W'(need);
              alloc_q <= used_q[IDX_W-1:0];
              state_q <= ST_ALLOC;
            end else begin
              ovf_q   <= 1'b1;
              state_q <= ST_IDLE;
            end
          end else if (walk_stop || walk_last) begin
            state_q <= (kind_q == CMD_QUERY) ? ST_RESULT : ST_IDLE;
          end else begin
            node_q  <= nx;
            level_q <= lvl_dn;
          end
        end
        ST_ALLOC: begin
          alloc_q <= alloc_q + 1'b1;
          level_q <= lvl_dn;
          if (level_q == '0) begin
            state_q <= ST_IDLE;
          end
        end
        ST_RESULT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= FIELD_W'(res_q);
            m_axis_tuser  <= ovf_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/binary_trie_min_xor_set.sv -----
// Top level of the binary trie min-xor set: front end, command queue, back end.
// Xor item: handled by the back end in its idle state. Insert: a trie walk (one node read
// per cycle from the node RAM) plus one write per new node. Query: a trie walk, then
// the output register, which waits while the output is stalled.
// Reset: an init pass writes the path of key zero into the node RAM; items are
// queued meanwhile. Mask, node count and overflow flag clear at once.
`timescale 1ns / 1ps
`default_nettype none
module binary_trie_min_xor_set (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [btmx_pkg::FIELD_W-1:0] s_axis_tdata,  // operand_value
  input  wire logic [btmx_pkg::OP_W-1:0]    s_axis_tuser,  // operation
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic      [btmx_pkg::FIELD_W-1:0] m_axis_tdata,  // min_xor_value
  output logic                              m_axis_tuser   // overflowed
);
  import btmx_pkg::*;

  logic push, full, pop, empty;
  cmd_t cmd_in, cmd_out;

  btmx_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  btmx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (cmd_out)
  );

  btmx_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .cmd_i         (cmd_out),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire

// ----- test/binary_trie_min_xor_set_tb.sv -----
// Self-checking testbench for the binary trie min-xor set with a trie predictor.
`timescale 1ns / 1ps
module binary_trie_min_xor_set_tb;
  import btmx_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int              CYCLE_LIMIT = 500000;
  localparam int              DIR_ROWS    = 25;
  localparam int              PHASE_ITEMS = 209;
  localparam int              SETTLE      = 50;

  typedef struct packed {
    logic [FIELD_W-1:0] min_val;
    logic               ovf;
  } minimum_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] val;
    logic               typed;
    logic [FIELD_W-1:0] exp_min;
    logic               exp_ovf;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [FIELD_W-1:0] s_axis_tdata  = '0;  // operand_value
  logic [OP_W-1:0]    s_axis_tuser  = '0;  // operation
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [FIELD_W-1:0] m_axis_tdata;        // min_xor_value
  logic               m_axis_tuser;        // overflowed

  binary_trie_min_xor_set i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // predictor state
  logic [IDX_W-1:0]    link_lo [NODE_COUNT];
  logic [IDX_W-1:0]    link_hi [NODE_COUNT];
  int                  nodes_used;
  logic [KEY_BITS-1:0] trie_mask;
  logic                trie_overflow;

  minimum_t            pending_minima [$];
  logic [KEY_BITS-1:0] key_pool [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int minima_checked = 0;
  int items_sent     = 0;
  int items_ignored  = 0;
  int inserts_dropped = 0;
  int cycle_count    = 0;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{OP_QUERY,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{OP_XOR,    32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{OP_QUERY,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{OP_INSERT, 32'h0000_0000, 1'b0, 32'h0,         1'b0},
    '{OP_QUERY,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{OP_XOR,    32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{OP_QUERY,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
    '{OP_UNUSED, 32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{OP_QUERY,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{OP_INSERT, 32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{OP_XOR,    32'h8000_0000, 1'b0, 32'h0,         1'b0},
    '{OP_QUERY,  32'h0000_0000, 1'b0, 32'h0,         1'b0},
    '{OP_INSERT, 32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{OP_XOR,    32'h0000_0001, 1'b0, 32'h0,         1'b0},
    '{OP_QUERY,  32'h0000_0000, 1'b0, 32'h0,         1'b0},
    '{OP_INSERT, 32'h0000_0001, 1'b0, 32'h0,         1'b0},
    '{OP_XOR,    32'h8000_0001, 1'b0, 32'h0,         1'b0},
    '{OP_QUERY,  32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
    '{OP_INSERT, 32'h5555_5555, 1'b0, 32'h0,         1'b0},
    '{OP_XOR,    32'hAAAA_AAAA, 1'b0, 32'h0,         1'b0},
    '{OP_QUERY,  32'h0000_0000, 1'b0, 32'h0,         1'b0},
    '{OP_QUERY,  32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{OP_XOR,    32'h0000_0000, 1'b0, 32'h0,         1'b0},
    '{OP_INSERT, 32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
    '{OP_QUERY,  32'h0000_0000, 1'b0, 32'h0,         1'b0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void trie_clear();
    for (int i = 0; i < NODE_COUNT; i++) begin
      link_lo[i] = '0;
      link_hi[i] = '0;
    end
    for (int i = 0; i < KEY_BITS; i++) begin
      link_lo[i] = IDX_W'(i + 1);
    end
    nodes_used    = KEY_BITS + 1;
    trie_mask     = '0;
    trie_overflow = 1'b0;
  endfunction

  // all or nothing: a key that does not fit leaves the trie untouched
  function automatic void trie_add(input logic [KEY_BITS-1:0] key);
    int node;
    int nx;
    int need;
    node = 0;
    need = 0;
    for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
      nx = key[lvl] ? link_hi[node] : link_lo[node];
      if (nx == 0) begin
        need = lvl + 1;
        break;
      end
      node = nx;
    end
    if (need > NODE_COUNT - nodes_used) begin
      trie_overflow = 1'b1;
      inserts_dropped++;
      return;
    end
    node = 0;
    for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
      nx = key[lvl] ? link_hi[node] : link_lo[node];
      if (nx == 0) begin
        nx = nodes_used;
        nodes_used++;
        link_lo[nx] = '0;
        link_hi[nx] = '0;
        if (key[lvl]) begin
          link_hi[node] = IDX_W'(nx);
        end else begin
          link_lo[node] = IDX_W'(nx);
        end
      end
      node = nx;
    end
  endfunction

  function automatic logic [KEY_BITS-1:0] min_xor_walk(input logic [KEY_BITS-1:0] m);
    int                  node;
    int                  nx;
    logic [KEY_BITS-1:0] acc;
    node = 0;
    acc  = '0;
    for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
      nx = m[lvl] ? link_hi[node] : link_lo[node];
      if (nx == 0) begin
        nx = m[lvl] ? link_lo[node] : link_hi[node];
        if (nx == 0) begin
          break;
        end
        acc[lvl] = 1'b1;
      end
      node = nx;
    end
    return acc;
  endfunction

  task automatic report_error(input string msg);
    $display("cycle %0d: mismatch: %s", cycle_count, msg);
    mismatches++;
  endtask

  // one item through the handshake, then into the predictor
  task automatic send_item(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] val,
                           input logic typed, input logic [FIELD_W-1:0] t_min,
                           input logic t_ovf);
    minimum_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    case (op)
      OP_INSERT: begin
        trie_add(val ^ trie_mask);
        key_pool.insert(key_pool.size(), val ^ trie_mask);
      end
      OP_XOR: begin
        trie_mask = trie_mask ^ val;
      end
      OP_QUERY: begin
        r.min_val = min_xor_walk(trie_mask);
        r.ovf     = trie_overflow;
        if (typed) begin
          r.min_val = t_min;
          r.ovf     = t_ovf;
        end
        pending_minima.insert(pending_minima.size(), r);
      end
      default: begin
        items_ignored++;
      end
    endcase
    items_sent++;
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_minima.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [FIELD_W-1:0] edge_value();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h0000_0001;
      default: return 32'h1 << $urandom_range(31);
    endcase
  endfunction

  function automatic logic [KEY_BITS-1:0] pool_key();
    return key_pool.size() == 0 ? '0 : key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  // some inserts land near stored keys so the trie fills with shared prefixes
  task automatic send_random(output bit counted);
    logic [OP_W-1:0]     op;
    logic [FIELD_W-1:0]  val;
    logic [KEY_BITS-1:0] key;
    int                  pick;
    int                  sel;
    pick = $urandom_range(99);
    sel  = $urandom_range(99);
    val  = $urandom;
    if (pick < 4) begin
      op = OP_UNUSED;
    end else if (pick < 46) begin
      op = OP_INSERT;
      if (sel < 30) begin
        key = pool_key() ^ ($urandom & ((32'h1 << $urandom_range(31)) - 32'h1));
        val = key ^ trie_mask;
      end else if (sel < 45) begin
        val = edge_value();
      end else if (sel < 55) begin
        val = $urandom_range(255);
      end
    end else if (pick < 62) begin
      op = OP_XOR;
      if (sel < 20) begin
        val = 32'h1 << $urandom_range(31);
      end else if (sel < 40) begin
        val = pool_key() ^ trie_mask;
      end else if (sel < 60) begin
        val = edge_value();
      end
    end else begin
      op = OP_QUERY;
    end
    send_item(op, val, 1'b0, '0, 1'b0);
    counted = (op != OP_UNUSED);
  endtask

  always @(posedge clk_i) begin : result_check
    minimum_t want;
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_minima.size() == 0) begin
        report_error($sformatf("unexpected result min %h ovf %b", m_axis_tdata, m_axis_tuser));
      end else begin
        want = pending_minima.pop_front();
        minima_checked++;
        if (m_axis_tdata !== want.min_val) begin
          report_error($sformatf("min_xor_value got %h want %h", m_axis_tdata, want.min_val));
        end
        if (m_axis_tuser !== want.ovf) begin
          report_error($sformatf("overflowed got %b want %b", m_axis_tuser, want.ovf));
        end
      end
    end
  end

  initial begin : stimulus
    bit counted;
    int n;
    trie_clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_table[i].op, dir_table[i].val, dir_table[i].typed,
                dir_table[i].exp_min, dir_table[i].exp_ovf);
    end
    hold_until_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 13 : (phase == 1) ? 48 : 0;
      recv_stall_pct = (phase == 0) ? 48 : (phase == 1) ? 13 : 0;
      n = 0;
      while (n < PHASE_ITEMS) begin
        send_random(counted);
        if (counted) begin
          n++;
        end
        if (phase == 0 && n == PHASE_ITEMS / 2 && counted) begin
          hold_until_drained();
        end
      end
      hold_until_drained();
    end

    repeat (SETTLE) @(posedge clk_i);
    $display("%0d items sent (%0d with unused code), %0d minima checked",
             items_sent, items_ignored, minima_checked);
    $display("trie filled to %0d of %0d nodes, %0d inserts dropped for lack of room",
             nodes_used, NODE_COUNT, inserts_dropped);
    if (mismatches == 0 && pending_minima.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/btmx_pkg.sv
hdl/btmx_ram.sv
hdl/btmx_front.sv
hdl/btmx_fifo.sv
hdl/btmx_back.sv
hdl/binary_trie_min_xor_set.sv
test/binary_trie_min_xor_set_tb.sv
